>>> rtl/dfi_pkg.sv
// Shared types, constants and the twiddle lookup of the direct DFT block.
// Used by the controller, the datapath and the top level.
`default_nettype none

package dfi_pkg;

  localparam int POINTS   = 64;
  localparam int PTR_W    = $clog2(POINTS);
  localparam int SAMPLE_W = 16;
  localparam int TW_W     = 16;
  localparam int PROD_W   = SAMPLE_W + TW_W;
  localparam int ACC_W    = 40;
  localparam int OUT_W    = 24;
  localparam int FRAC     = 15;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_real;
    logic signed [SAMPLE_W-1:0] in_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_real;
    logic signed [OUT_W-1:0] out_imag;
    logic                    out_last;
  } out_item_t;

  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic [PTR_W-1:0] tw_idx;
    logic             first;
    logic             last;
    logic             load_out;
    logic             out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_done;
    logic out_free;
  } dp_status_t;

  // Quarter wave of sin(j*pi/32) in Q1.15 magnitude, full scale held as 32768.
  localparam logic [TW_W:0] QSIN [17] = '{
    17'd0,     17'd3212,  17'd6393,  17'd9512,  17'd12540, 17'd15447,
    17'd18205, 17'd20788, 17'd23170, 17'd25330, 17'd27246, 17'd28899,
    17'd30274, 17'd31357, 17'd32138, 17'd32610, 17'd32768
  };

  localparam logic [TW_W:0] FULL_MAG = 17'd32768;
  localparam logic [TW_W:0] POS_MAX  = 17'd32767;

  function automatic logic signed [TW_W-1:0] tw_sin(input logic [PTR_W-1:0] m);
    logic [1:0]       quad;
    logic [PTR_W-3:0] r;
    logic [PTR_W-2:0] j;
    logic [TW_W:0]    mag;
    logic [TW_W:0]    val;
    quad = m[PTR_W-1:PTR_W-2];
    r    = m[PTR_W-3:0];
    if (quad[0]) begin
      j = (PTR_W-1)'(POINTS / 4) - {1'b0, r};
    end else begin
      j = {1'b0, r};
    end
    mag = QSIN[j];
    if (quad[1]) begin
      val = -mag;
    end else if (mag == FULL_MAG) begin
      val = POS_MAX;
    end else begin
      val = mag;
    end
    return val[TW_W-1:0];
  endfunction

  function automatic logic signed [TW_W-1:0] tw_cos(input logic [PTR_W-1:0] m);
    return tw_sin(m + PTR_W'(POINTS / 4));
  endfunction

endpackage

`default_nettype wire

>>> rtl/dfi_ctrl.sv
// Sequencer of the direct DFT: frame load, per-bin MAC sweep, drain and emit.
// Depends on dfi_pkg for the command and status structs.
`default_nettype none

module dfi_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dfi_pkg::dp_status_t status_i,
  output dfi_pkg::dp_cmd_t    cmd_o
);
  import dfi_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(POINTS - 1);

  state_e           state_q, state_d;
  logic [PTR_W-1:0] cnt_q, cnt_d;
  logic [PTR_W-1:0] k_q, k_d;
  logic [PTR_W-1:0] n_q, n_d;
  logic [PTR_W-1:0] m_q, m_d;

  always_comb begin
    state_d           = state_q;
    cnt_d             = cnt_q;
    k_d               = k_q;
    n_d               = n_q;
    m_d               = m_q;
    in_stall_o        = 1'b1;
    cmd_o             = '0;
    cmd_o.wr_addr     = cnt_q;
    cmd_o.rd_addr     = n_q;
    cmd_o.tw_idx      = m_q;
    cmd_o.out_last    = (k_q == LAST_IDX);
    unique case (state_q)
      S_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.wr_en = 1'b1;
          cnt_d       = cnt_q + 1'b1;
          if (cnt_q == LAST_IDX) begin
            state_d = S_RUN;
            k_d     = '0;
            n_d     = '0;
            m_d     = '0;
          end
        end
      end
      S_RUN: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.first = (n_q == '0);
        cmd_o.last  = (n_q == LAST_IDX);
        n_d         = n_q + 1'b1;
        m_d         = m_q + k_q;
        if (n_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (status_i.acc_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (k_q == LAST_IDX) begin
            state_d = S_LOAD;
          end else begin
            k_d     = k_q + 1'b1;
            n_d     = '0;
            m_d     = '0;
            state_d = S_RUN;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      k_q     <= '0;
      n_q     <= '0;
      m_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      n_q     <= n_d;
      m_q     <= m_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dfi_datapath.sv
// Datapath of the direct DFT: sample store, twiddle lookup, complex MAC,
// scaling with saturation, direction register and output register.
// Depends on dfi_pkg for types, constants and the twiddle functions.
`default_nettype none

module dfi_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dfi_pkg::in_item_t   in_item_i,
  input  dfi_pkg::dp_cmd_t    cmd_i,
  output dfi_pkg::dp_status_t status_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dfi_pkg::out_item_t  out_item_o
);
  import dfi_pkg::*;

  localparam logic signed [ACC_W-1:0] RND_FWD = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] RND_INV = ACC_W'(1) << (FRAC + PTR_W - 1);

  logic signed [SAMPLE_W-1:0] mem_re_q [POINTS];
  logic signed [SAMPLE_W-1:0] mem_im_q [POINTS];

  logic signed [SAMPLE_W-1:0] xr_q, xi_q;
  logic signed [TW_W-1:0]     c_q, s_q;
  logic                       v1_q, first1_q, last1_q;

  logic signed [PROD_W-1:0]   p_rc_q, p_is_q, p_rs_q, p_ic_q;
  logic                       v2_q, first2_q, last2_q;

  logic signed [ACC_W-1:0]    acc_re_q, acc_im_q;
  logic signed [ACC_W-1:0]    term_re, term_im;
  logic                       done_q;

  logic                       dir_q;
  logic                       out_valid_q;
  out_item_t                  out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_re_q[cmd_i.wr_addr] <= in_item_i.in_real;
      mem_im_q[cmd_i.wr_addr] <= in_item_i.in_imag;
    end
    if (cmd_i.rd_en) begin
      xr_q <= mem_re_q[cmd_i.rd_addr];
      xi_q <= mem_im_q[cmd_i.rd_addr];
      c_q  <= tw_cos(cmd_i.tw_idx);
      s_q  <= tw_sin(cmd_i.tw_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    p_rc_q <= xr_q * c_q;
    p_is_q <= xi_q * s_q;
    p_rs_q <= xr_q * s_q;
    p_ic_q <= xi_q * c_q;
  end

  always_comb begin
    if (dir_q) begin
      term_re = ACC_W'(p_rc_q) - ACC_W'(p_is_q);
      term_im = ACC_W'(p_rs_q) + ACC_W'(p_ic_q);
    end else begin
      term_re = ACC_W'(p_rc_q) + ACC_W'(p_is_q);
      term_im = ACC_W'(p_ic_q) - ACC_W'(p_rs_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      if (first2_q) begin
        acc_re_q <= term_re;
        acc_im_q <= term_im;
      end else begin
        acc_re_q <= acc_re_q + term_re;
        acc_im_q <= acc_im_q + term_im;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      first1_q <= 1'b0;
      last1_q  <= 1'b0;
      v2_q     <= 1'b0;
      first2_q <= 1'b0;
      last2_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      v1_q     <= cmd_i.rd_en;
      first1_q <= cmd_i.first;
      last1_q  <= cmd_i.last;
      v2_q     <= v1_q;
      first2_q <= first1_q;
      last2_q  <= last1_q;
      done_q   <= v2_q && last2_q;
    end
  end

  function automatic logic signed [OUT_W-1:0] scale_sat(input logic signed [ACC_W-1:0] acc,
                                                        input logic inv);
    logic signed [ACC_W-1:0] t;
    logic signed [OUT_W-1:0] r;
    if (inv) begin
      t = (acc + RND_INV) >>> (FRAC + PTR_W);
    end else begin
      t = (acc + RND_FWD) >>> FRAC;
    end
    if (t[ACC_W-1:OUT_W-1] == '0 || t[ACC_W-1:OUT_W-1] == '1) begin
      r = t[OUT_W-1:0];
    end else if (t[ACC_W-1]) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign status_o.acc_done = done_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dir_q <= cfg_wdata_i;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.out_real <= scale_sat(acc_re_q, dir_q);
      out_q.out_imag <= scale_sat(acc_im_q, dir_q);
      out_q.out_last <= cmd_i.out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/dft_forward_inverse.sv
// Direct 64-point DFT, forward or inverse, one complex MAC per cycle while a bin is swept.
// Each bin sums 64 products through the single complex MAC, then drains the pipeline;
// samples are not taken while the bins of a frame are computed, so a new frame is
// loaded only after the last bin of the previous one is in the output register.
// Reset clears control state and the direction register; the sample store is not cleared.
`default_nettype none

module dft_forward_inverse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dfi_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dfi_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i
);
  import dfi_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dfi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dfi_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
